// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Include guarded; no other content.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every edge outside reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/uawt_pkg.sv -----
// Package for the ack window tracker: widths, commands, register indexes.
// No dependencies.
package uawt_pkg;
  localparam int unsigned SeqW = 16;
  localparam int unsigned BitsW = 32;
  localparam int unsigned DefSlots = 32;
  localparam logic [15:0] HalfRange = 16'd32767;
  localparam logic [15:0] AgeMax = 16'hFFFF;
  localparam logic [15:0] DropReset = 16'd32;
  localparam logic [15:0] KaReset = 16'd100;

  typedef enum logic [1:0] {
    CmdRelSend = 2'd0,
    CmdUnrelSend = 2'd1,
    CmdRecv = 2'd2,
    CmdTick = 2'd3
  } cmd_e;

  localparam logic [0:0] RegDrop = 1'b0;
  localparam logic [0:0] RegKa = 1'b1;

  function automatic logic newer_than(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    newer_than = (a != b) && (d <= HalfRange);
  endfunction
endpackage

// ----- hw/rtl/uawt_if.sv -----
// Channel interfaces: input, output and configuration words.
// No dependencies.
interface uawt_in_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [15:0] rx_seq;
  logic [15:0] rx_ack;
  logic [31:0] rx_ack_bits;
  modport source (output valid, command, rx_seq, rx_ack, rx_ack_bits, input ready);
  modport sink (input valid, command, rx_seq, rx_ack, rx_ack_bits, output ready);
endinterface

interface uawt_out_if;
  logic valid;
  logic ready;
  logic [15:0] tx_seq;
  logic [15:0] tx_ack;
  logic [31:0] tx_ack_bits;
  logic slot_overwritten;
  logic stale_packet;
  logic [31:0] acked_mask;
  logic [31:0] timeout_mask;
  logic keepalive_due;
  modport source (output valid, tx_seq, tx_ack, tx_ack_bits, slot_overwritten,
    stale_packet, acked_mask, timeout_mask, keepalive_due, input ready);
  modport sink (input valid, tx_seq, tx_ack, tx_ack_bits, slot_overwritten,
    stale_packet, acked_mask, timeout_mask, keepalive_due, output ready);
endinterface

interface uawt_cfg_if;
  logic valid;
  logic ready;
  logic [31:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/uawt_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module uawt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hw/rtl/udp_ack_window_tracker.sv -----
// Channel  | dir | payload
// in_w     | in  | command, rx_seq, rx_ack, rx_ack_bits
// out_w    | out | tx header, status, masks
// cfg_w    | in  | index, data
// Sends pass through StExec and StDone to the output register, then the next word is taken.
// Receive and tick walk the slot RAM, reading one slot each cycle and handling
// the one before it; a tick writes back the aged entry. A stale receive
// skips the walk, like a send. The output register holds a word until taken;
// the next word is accepted meanwhile, its result waits for the register.
// Slot valid bits are flops.
// Depends on uawt_pkg, uawt_if, uawt_ram.
module udp_ack_window_tracker
  import uawt_pkg::*;
#(
  parameter int unsigned Slots = DefSlots
) (
  input logic clk_i,
  input logic rst_ni,
  uawt_in_if.sink in_w,
  uawt_out_if.source out_w,
  uawt_cfg_if.sink cfg_w
);
  localparam int unsigned AW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [AW-1:0] SlotReset = AW'(16'hFFFF % Slots);
  localparam logic [AW-1:0] SlotLast = AW'(Slots - 1);
  localparam logic [AW:0] WalkEnd = (AW+1)'(Slots);

  typedef enum logic [1:0] {StIdle, StExec, StWalk, StDone} state_e;

  state_e state_q;
  logic [1:0] cmd_q;
  logic [15:0] rxs_q, rxa_q;
  logic [31:0] rxb_q;
  logic [15:0] drop_q, ka_q, lseq_q, pseq_q, idle_q;
  logic [AW-1:0] slot_q;
  logic [31:0] pbits_q;
  logic [Slots-1:0] valid_q;
  logic [AW:0] idx_q;
  logic stale_q, ovw_q;
  logic [31:0] ack_q, exp_q;
  logic out_full_q;

  logic [15:0] out_seq_q, out_pseq_q;
  logic [31:0] out_bits_q, out_ack_q, out_exp_q;
  logic out_ovw_q, out_stale_q, out_ka_q;

  logic ram_we;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] ram_wd, ram_rd;

  uawt_ram #(.Width(32), .Depth(Slots)) u_slot_ram (
    .clk_i, .we_i(ram_we), .waddr_i(wr_addr), .wdata_i(ram_wd),
    .raddr_i(rd_addr), .rdata_o(ram_rd)
  );

  // walk: read address idx, process entry idx-1 (data returns next cycle)
  logic in_walk;
  logic [AW-1:0] prev;
  logic [15:0] sseq, sage, nage;
  logic [15:0] kd;
  logic ackhit, exphit, pv, hit;
  assign in_walk = (state_q == StWalk) && (idx_q != '0);
  assign prev = AW'(idx_q - 1'b1);
  assign sseq = ram_rd[31:16];
  assign sage = ram_rd[15:0];
  assign pv = valid_q[prev];
  assign kd = rxa_q - sseq;
  assign ackhit = pv && (newer_than(rxa_q, sseq) || sseq == rxa_q) &&
                  (kd < 16'd32) && rxb_q[kd[4:0]];
  assign nage = (sage == AgeMax) ? sage : sage + 16'd1;
  assign exphit = pv && (nage >= drop_q);
  assign hit = in_walk && ((cmd_q == CmdRecv) ? ackhit : exphit);

  // slot of the next sequence: seq mod Slots, back to zero when seq wraps
  logic [15:0] seq_next;
  logic [AW-1:0] slot_next;
  assign seq_next = lseq_q + 16'd1;
  assign slot_next = (seq_next == '0 || slot_q == SlotLast) ? '0 : slot_q + AW'(1);

  always_comb begin
    rd_addr = (idx_q < WalkEnd) ? idx_q[AW-1:0] : '0;
    wr_addr = prev;
    ram_we = 1'b0;
    ram_wd = {sseq, nage};
    if (state_q == StExec) begin
      wr_addr = slot_next;
      ram_we = (cmd_q == CmdRelSend);
      ram_wd = {seq_next, 16'd0};
    end else if (in_walk) begin
      ram_we = (cmd_q == CmdTick) && pv;
    end
  end

  assign in_w.ready = (state_q == StIdle);
  assign cfg_w.ready = 1'b1;

  logic out_load;
  assign out_load = (state_q == StDone) && (!out_full_q || out_w.ready);

  logic [15:0] pseq_d;
  logic [31:0] pbits_d, sh_bits;
  logic [15:0] dd, dn;
  always_comb begin
    pseq_d = pseq_q;
    sh_bits = pbits_q;
    dd = rxs_q - pseq_q;
    if (newer_than(rxs_q, pseq_q)) begin
      sh_bits = (dd < 16'd32) ? (pbits_q << dd[4:0]) : 32'd0;
      pseq_d = rxs_q;
    end
    dn = pseq_d - rxs_q;
    pbits_d = sh_bits | ((dn < 16'd32) ? (32'd1 << dn[4:0]) : 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cmd_q <= '0;
      rxs_q <= '0;
      rxa_q <= '0;
      rxb_q <= '0;
      drop_q <= DropReset;
      ka_q <= KaReset;
      lseq_q <= 16'hFFFF;
      slot_q <= SlotReset;
      pseq_q <= '0;
      pbits_q <= '0;
      idle_q <= '0;
      valid_q <= '0;
      idx_q <= '0;
      stale_q <= 1'b0;
      ovw_q <= 1'b0;
      ack_q <= '0;
      exp_q <= '0;
      out_full_q <= 1'b0;
      out_seq_q <= '0;
      out_pseq_q <= '0;
      out_bits_q <= '0;
      out_ovw_q <= 1'b0;
      out_stale_q <= 1'b0;
      out_ack_q <= '0;
      out_exp_q <= '0;
      out_ka_q <= 1'b0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        if (cfg_w.index == 32'(RegDrop)) drop_q <= cfg_w.data;
        else if (cfg_w.index == 32'(RegKa)) ka_q <= cfg_w.data;
      end
      if (out_load) out_full_q <= 1'b1;
      else if (out_w.valid && out_w.ready) out_full_q <= 1'b0;
      if (out_load) begin
        out_seq_q <= lseq_q;
        out_pseq_q <= pseq_q;
        out_bits_q <= pbits_q;
        out_ovw_q <= ovw_q;
        out_stale_q <= stale_q;
        out_ack_q <= ack_q;
        out_exp_q <= exp_q;
        out_ka_q <= (cmd_q == CmdTick) && (idle_q >= ka_q);
      end
      unique case (state_q)
        StIdle: begin
          if (in_w.valid) begin
            cmd_q <= in_w.command;
            rxs_q <= in_w.rx_seq;
            rxa_q <= in_w.rx_ack;
            rxb_q <= in_w.rx_ack_bits;
            ovw_q <= 1'b0; stale_q <= 1'b0;
            ack_q <= '0; exp_q <= '0;
            idx_q <= '0;
            state_q <= StExec;
          end
        end
        StExec: begin
          if (cmd_q == CmdRelSend || cmd_q == CmdUnrelSend) begin
            lseq_q <= seq_next;
            slot_q <= slot_next;
            idle_q <= '0;
            if (cmd_q == CmdRelSend) begin
              ovw_q <= valid_q[slot_next];
              valid_q[slot_next] <= 1'b1;
            end
            state_q <= StDone;
          end else if (cmd_q == CmdRecv) begin
            pseq_q <= pseq_d;
            pbits_q <= pbits_d;
            idle_q <= '0;
            if (newer_than(pseq_d, rxs_q)) begin
              stale_q <= 1'b1;
              state_q <= StDone;
            end else state_q <= StWalk;
          end else begin
            idle_q <= (idle_q == AgeMax) ? idle_q : idle_q + 16'd1;
            state_q <= StWalk;
          end
        end
        StWalk: begin
          if (hit) begin
            valid_q[prev] <= 1'b0;
            if (cmd_q == CmdRecv) ack_q[prev] <= 1'b1;
            else exp_q[prev] <= 1'b1;
          end
          if (idx_q == WalkEnd) state_q <= StDone;
          idx_q <= idx_q + 1'b1;
        end
        StDone: begin
          if (out_load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_w.valid = out_full_q;
  assign out_w.tx_seq = out_seq_q;
  assign out_w.tx_ack = out_pseq_q;
  assign out_w.tx_ack_bits = out_bits_q;
  assign out_w.slot_overwritten = out_ovw_q;
  assign out_w.stale_packet = out_stale_q;
  assign out_w.acked_mask = out_ack_q;
  assign out_w.timeout_mask = out_exp_q;
  assign out_w.keepalive_due = out_ka_q;
endmodule

// ----- hw/rtl/uawt_checker.sv -----
// Port-level checker for the tracker, bound to the top level.
// Depends on assert_macros.svh, uawt_if.
`include "assert_macros.svh"
module uawt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid, in_ready, out_valid, out_ready,
  input logic [31:0] ack_m, exp_m,
  input logic stale, ovw, ka
);
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid && in_ready, !in_ready)
  `ASSERT_IMPL(a_one_mask, clk_i, rst_ni, out_valid, (ack_m == 0) || (exp_m == 0))
  `ASSERT_IMPL(a_stale_noack, clk_i, rst_ni, out_valid && stale, ack_m == 0)
  `ASSERT_IMPL(a_ovw_excl, clk_i, rst_ni, out_valid && ovw, !stale && !ka && exp_m == 0)
endmodule

bind udp_ack_window_tracker uawt_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_w.valid), .in_ready(in_w.ready),
  .out_valid(out_w.valid), .out_ready(out_w.ready),
  .ack_m(out_w.acked_mask), .exp_m(out_w.timeout_mask),
  .stale(out_w.stale_packet), .ovw(out_w.slot_overwritten), .ka(out_w.keepalive_due)
);
